// File: design/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg: shared types and codes for the sorted list pool
// Operation and status codes, beat structs, and slot-scan control.
// ----------------------------------------------------------------------------
package slp_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SHOW   = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned RemovedW = 5;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [SlotW-1:0]         slot;
    logic signed [ValueW-1:0] entry_value;
    logic [RemovedW-1:0]      removed;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic scan_clr;
    logic set;
    logic clr;
  } scan_ctrl_t;

endpackage

// File: design/slp_ent_ram.sv
// ----------------------------------------------------------------------------
// slp_ent_ram: ordered entry store
// One write port and one registered read port; each word is {slot, value}.
// ----------------------------------------------------------------------------
module slp_ent_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 36
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/slp_free_scan.sv
// ----------------------------------------------------------------------------
// slp_free_scan: slot occupancy and lowest-free-slot search
// Holds one used bit per pool slot and steps a search index one slot a cycle until it finds a free slot.
// ----------------------------------------------------------------------------
module slp_free_scan #(
  parameter int unsigned POOL_SIZE = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slp_pkg::scan_ctrl_t          ctrl_i,
  input  logic [$clog2(POOL_SIZE)-1:0] clr_idx_i,
  output logic [$clog2(POOL_SIZE)-1:0] free_idx_o
);

  import slp_pkg::*;

  localparam int unsigned IW = $clog2(POOL_SIZE);

  logic [POOL_SIZE-1:0] used_q;
  logic [IW-1:0]        idx_q;
  logic                 found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.scan_clr) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (!found_q) begin
      if (!used_q[idx_q]) begin
        found_q <= 1'b1;
      end else begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      if (ctrl_i.set) begin
        used_q[idx_q] <= 1'b1;
      end
      if (ctrl_i.clr) begin
        used_q[clr_idx_i] <= 1'b0;
      end
    end
  end

  assign free_idx_o = idx_q;

endmodule

// File: design/sorted_list_pool.sv
// ----------------------------------------------------------------------------
// sorted_list_pool: sorted list of signed values in a fixed slot pool
// Insert and delete walk every entry held; show streams one beat per entry.
//   Full insert, empty show and unused kinds answer without a walk.
// The walk of the store reads one entry per cycle; a new command is taken
//   only while idle (busy low).
// Reset clears the list and all slot used bits; results go out unstalled.
// ----------------------------------------------------------------------------
module sorted_list_pool #(
  parameter int unsigned POOL_SIZE = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  slp_pkg::in_t   in_i,
  output logic           busy,
  output logic           res_valid_o,
  output slp_pkg::out_t  res_o
);

  import slp_pkg::*;

  localparam int unsigned IW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);
  localparam int unsigned EW = IW + ValueW;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_WALK    = 2'd1;
  localparam logic [1:0] ST_INS_FIN = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [1:0]               kind_q, kind_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            ri_q, ri_d;
  logic                     dv_q, dv_d;
  logic [IW-1:0]            pi_q, pi_d;
  logic                     placed_q, placed_d;
  logic [IW-1:0]            pos_q, pos_d;
  logic [EW-1:0]            carry_q, carry_d;
  logic [CW-1:0]            wr_q, wr_d;
  logic [CW-1:0]            rem_q, rem_d;
  logic                     out_vld_q, out_vld_d;
  out_t                     out_q, out_d;

  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic [EW-1:0]            rd_data;
  logic                     wr_en;
  logic [IW-1:0]            wr_addr;
  logic [EW-1:0]            wr_data;

  scan_ctrl_t               scan_ctrl;
  logic [IW-1:0]            clr_idx;
  logic [IW-1:0]            free_idx;

  logic [IW-1:0]            e_slot;
  logic signed [ValueW-1:0] e_val;
  logic                     e_ge;
  logic                     e_eq;
  logic                     accept;

  assign e_slot = rd_data[EW-1:ValueW];
  assign e_val  = $signed(rd_data[ValueW-1:0]);
  assign e_ge   = (e_val >= val_q);
  assign e_eq   = (e_val == val_q);
  assign accept = start && (state_q == ST_IDLE);

  slp_ent_ram #(
    .DEPTH (POOL_SIZE),
    .WIDTH (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  slp_free_scan #(
    .POOL_SIZE (POOL_SIZE)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .clr_idx_i  (clr_idx),
    .free_idx_o (free_idx)
  );

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    ri_d      = ri_q;
    dv_d      = 1'b0;
    pi_d      = pi_q;
    placed_d  = placed_q;
    pos_d     = pos_q;
    carry_d   = carry_q;
    wr_d      = wr_q;
    rem_d     = rem_q;
    out_vld_d = 1'b0;
    out_d     = out_q;
    rd_en     = 1'b0;
    rd_addr   = ri_q[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = pi_q;
    wr_data   = rd_data;
    scan_ctrl = '0;
    clr_idx   = e_slot;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d   = in_i.kind;
          val_d    = in_i.value;
          ri_d     = '0;
          placed_d = 1'b0;
          wr_d     = '0;
          rem_d    = '0;
          scan_ctrl.scan_clr = 1'b1;
          out_d      = '0;
          out_d.last = 1'b1;
          case (in_i.kind)
            KIND_INSERT: begin
              if (cnt_q == CW'(POOL_SIZE)) begin
                out_d.status = STATUS_FULL;
                out_vld_d    = 1'b1;
              end else begin
                state_d = ST_WALK;
              end
            end
            KIND_DELETE: begin
              state_d = ST_WALK;
            end
            KIND_SHOW: begin
              if (cnt_q == '0) begin
                out_d.status = STATUS_EMPTY;
                out_vld_d    = 1'b1;
              end else begin
                state_d = ST_WALK;
              end
            end
            default: begin
              out_vld_d = 1'b1;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (dv_q) begin
          case (kind_q)
            KIND_INSERT: begin
              if (placed_q) begin
                wr_en   = 1'b1;
                wr_addr = pi_q;
                wr_data = carry_q;
                carry_d = rd_data;
              end else if (e_ge) begin
                placed_d = 1'b1;
                pos_d    = pi_q;
                carry_d  = rd_data;
              end
            end
            KIND_DELETE: begin
              if (e_eq) begin
                scan_ctrl.clr = 1'b1;
                rem_d         = rem_q + CW'(1);
              end else begin
                wr_en   = 1'b1;
                wr_addr = wr_q[IW-1:0];
                wr_data = rd_data;
                wr_d    = wr_q + CW'(1);
              end
            end
            default: begin
              out_vld_d         = 1'b1;
              out_d.status      = STATUS_DONE;
              out_d.slot        = SlotW'(e_slot);
              out_d.entry_value = e_val;
              out_d.removed     = '0;
              out_d.last        = ((CW'(pi_q) + CW'(1)) == cnt_q);
            end
          endcase
        end

        if (ri_q < cnt_q) begin
          rd_en = 1'b1;
          ri_d  = ri_q + CW'(1);
          dv_d  = 1'b1;
          pi_d  = ri_q[IW-1:0];
        end else if (!dv_q) begin
          case (kind_q)
            KIND_INSERT: begin
              if (placed_q) begin
                wr_en   = 1'b1;
                wr_addr = cnt_q[IW-1:0];
                wr_data = carry_q;
              end else begin
                pos_d = cnt_q[IW-1:0];
              end
              state_d = ST_INS_FIN;
            end
            KIND_DELETE: begin
              cnt_d             = wr_q;
              out_vld_d         = 1'b1;
              out_d             = '0;
              out_d.status      = STATUS_DONE;
              out_d.removed     = RemovedW'(rem_q);
              out_d.last        = 1'b1;
              state_d           = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_INS_FIN: begin
        wr_en             = 1'b1;
        wr_addr           = pos_q;
        wr_data           = {free_idx, val_q};
        scan_ctrl.set     = 1'b1;
        cnt_d             = cnt_q + CW'(1);
        out_vld_d         = 1'b1;
        out_d             = '0;
        out_d.status      = STATUS_DONE;
        out_d.slot        = SlotW'(free_idx);
        out_d.entry_value = val_q;
        out_d.last        = 1'b1;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ri_q      <= '0;
      dv_q      <= 1'b0;
      placed_q  <= 1'b0;
      wr_q      <= '0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ri_q      <= ri_d;
      dv_q      <= dv_d;
      placed_q  <= placed_d;
      wr_q      <= wr_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    val_q   <= val_d;
    pi_q    <= pi_d;
    pos_q   <= pos_d;
    carry_q <= carry_d;
    out_q   <= out_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// File: design/slp_checker.sv
// ----------------------------------------------------------------------------
// slp_checker: port-level checks for the sorted list pool
// Watches input acceptance and result beats; bound to the top level.
// ----------------------------------------------------------------------------
module slp_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  logic          res_valid_o,
  input  slp_pkg::out_t res_o
);

  import slp_pkg::*;

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o))
    else $error("accepted item neither started a walk nor gave a beat");

  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy)
    else $error("non-final beat while idle");

  a_full_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == STATUS_FULL || res_o.status == STATUS_EMPTY))
      |-> (res_o.last && res_o.slot == '0 && res_o.removed == '0))
    else $error("full or empty beat malformed");

  a_removed_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.removed != '0)
      |-> (res_o.status == STATUS_DONE && res_o.last && res_o.slot == '0))
    else $error("delete beat malformed");

endmodule

bind sorted_list_pool slp_checker u_slp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// File: dv/tb_sorted_list_pool.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_pool: self-checking bench for the sorted list pool
// Sends insert, delete, show and unused-kind commands with random gaps. A
// behavioral list model predicts every result beat, and each strobed beat is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_list_pool;
  import slp_pkg::*;

  localparam int unsigned POOL_SIZE   = 16;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic start;
  in_t  in_i;
  logic busy;
  logic res_valid_o;
  out_t res_o;

  logic signed [ValueW-1:0] pool_value [POOL_SIZE];
  bit                       slot_taken [POOL_SIZE];
  bit [SlotW-1:0]           sorted_slots [$];
  out_t                     pending_results [$];
  int unsigned              err_cnt;
  bit                       no_gaps;

  sorted_list_pool #(
    .POOL_SIZE (POOL_SIZE)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .in_i        (in_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void apply_list_op(in_t op);
    out_t           res;
    int             free_slot;
    int             pos;
    int             s;
    int unsigned    hits;
    bit [SlotW-1:0] kept [$];
    res      = '0;
    res.last = 1'b1;
    case (op.kind)
      KIND_INSERT: begin
        free_slot = -1;
        for (s = POOL_SIZE - 1; s >= 0; s--) begin
          if (!slot_taken[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          res.status = STATUS_FULL;
        end else begin
          pos = sorted_slots.size();
          for (s = 0; s < sorted_slots.size(); s++) begin
            if (pool_value[sorted_slots[s]] >= op.value) begin
              pos = s;
              break;
            end
          end
          if (pos == sorted_slots.size()) sorted_slots.push_back(free_slot[SlotW-1:0]);
          else sorted_slots.insert(pos, free_slot[SlotW-1:0]);
          pool_value[free_slot] = op.value;
          slot_taken[free_slot] = 1'b1;
          res.slot              = free_slot[SlotW-1:0];
          res.entry_value       = op.value;
        end
        pending_results.push_back(res);
      end
      KIND_DELETE: begin
        hits = 0;
        foreach (sorted_slots[k]) begin
          if (pool_value[sorted_slots[k]] == op.value) begin
            slot_taken[sorted_slots[k]] = 1'b0;
            hits++;
          end else begin
            kept.push_back(sorted_slots[k]);
          end
        end
        sorted_slots = kept;
        res.removed  = hits[RemovedW-1:0];
        pending_results.push_back(res);
      end
      KIND_SHOW: begin
        if (sorted_slots.size() == 0) begin
          res.status = STATUS_EMPTY;
          pending_results.push_back(res);
        end else begin
          foreach (sorted_slots[k]) begin
            res.slot        = sorted_slots[k];
            res.entry_value = pool_value[sorted_slots[k]];
            res.last        = (k == sorted_slots.size() - 1);
            pending_results.push_back(res);
          end
        end
      end
      default: begin
        pending_results.push_back(res);
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) apply_list_op(in_i);
      if (res_valid_o) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, expected none, got %p", $time, res_o);
        end else begin
          compare_field("status", pending_results[0].status, res_o.status);
          compare_field("slot", pending_results[0].slot, res_o.slot);
          compare_field("entry_value", pending_results[0].entry_value, res_o.entry_value);
          compare_field("removed", pending_results[0].removed, res_o.removed);
          compare_field("last", pending_results[0].last, res_o.last);
          void'(pending_results.pop_front());
        end
      end
    end
  end

  task automatic send_op(input logic [1:0] kind, input logic signed [ValueW-1:0] value);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= '{kind: kind, value: value};
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh8000_0000;
      default: return $signed($urandom_range(0, 7)) - 4;
    endcase
  endfunction

  task automatic test_empty_list();
    send_op(KIND_SHOW, 32'sd0);
    send_op(KIND_DELETE, 32'sh8000_0000);
    send_op(KIND_UNUSED, 32'shffff_ffff);
  endtask

  task automatic test_ordering();
    send_op(KIND_INSERT, 32'sh7fff_ffff);
    send_op(KIND_INSERT, 32'sh8000_0000);
    send_op(KIND_INSERT, -32'sd1);
    send_op(KIND_INSERT, 32'sd0);
    send_op(KIND_INSERT, 32'sd5);
    send_op(KIND_INSERT, 32'sd5);
    send_op(KIND_SHOW, 32'sh5555_5555);
    send_op(KIND_DELETE, 32'sd5);
  endtask

  task automatic test_full_pool();
    int k;
    for (k = 0; k < 12; k++) send_op(KIND_INSERT, (k % 3) - 1);
    send_op(KIND_INSERT, 32'sd9);
    send_op(KIND_SHOW, 32'sh2aaa_aaaa);
  endtask

  task automatic test_head_reuse();
    send_op(KIND_DELETE, 32'sh8000_0000);
    send_op(KIND_INSERT, -32'sd7);
    send_op(KIND_DELETE, -32'sd1);
    send_op(KIND_SHOW, 32'sd0);
  endtask

  task automatic test_random_mix();
    int unsigned n;
    int unsigned pick;
    bit          filling;
    logic [1:0]  kind;
    filling = 1'b1;
    for (n = 0; n < 290; n++) begin
      if (n % 40 == 0) begin
        filling = (n == 0) || ($urandom_range(0, 1) == 1);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) kind = KIND_UNUSED;
      else if (pick < 15) kind = KIND_SHOW;
      else if (pick < (filling ? 75 : 40)) kind = KIND_INSERT;
      else kind = KIND_DELETE;
      send_op(kind, pick_value());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    in_i    = '0;
    err_cnt = 0;
    no_gaps = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_ordering();
    test_full_pool();
    test_head_reuse();
    test_random_mix();

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_sorted_list_pool OK");
    end else begin
      $display("tb_sorted_list_pool NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_sorted_list_pool NOT OK");
    $finish;
  end

endmodule
